@@ rtl/core/vbfd_pkg.sv @@
// Shared types, widths and constants of the black frame detector.
`timescale 1ns / 1ps

package vbfd_pkg;

  localparam int LUMA_W   = 8;
  localparam int THR_W    = 9;
  localparam int PCT_W    = 7;
  localparam int FRAMES_W = 16;
  localparam int COUNT_W  = 25;
  localparam int RUN_W    = 17;
  localparam int PROD_W   = 32;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;
  localparam int OUT_DW   = 8;

  // Summary queue between the pixel counter and the decision stage.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [COUNT_W-1:0] MAX_FRAME_PIXELS = COUNT_W'(16777216);
  localparam logic [RUN_W-1:0]   RUN_MAX          = {RUN_W{1'b1}};
  localparam logic [PCT_W-1:0]   PCT_SCALE        = PCT_W'(100);

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_PIXEL_THRESHOLD     = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PERCENT_BLACK       = 2'd1;
  localparam logic [CFG_AW-1:0] REG_BLACK_FRAMES_NEEDED = 2'd2;
  localparam logic [CFG_AW-1:0] REG_CLEAR_FRAMES_NEEDED = 2'd3;

  // Configuration reset values.
  localparam logic [THR_W-1:0]    RST_PIXEL_THRESHOLD     = THR_W'(32);
  localparam logic [PCT_W-1:0]    RST_PERCENT_BLACK       = PCT_W'(98);
  localparam logic [FRAMES_W-1:0] RST_BLACK_FRAMES_NEEDED = FRAMES_W'(56);
  localparam logic [FRAMES_W-1:0] RST_CLEAR_FRAMES_NEEDED = FRAMES_W'(0);

  typedef struct packed {
    logic [COUNT_W-1:0] dark;
    logic [COUNT_W-1:0] total;
  } frame_stats_t;

  typedef struct packed {
    logic [PCT_W-1:0]    percent_black;
    logic [FRAMES_W-1:0] black_frames_needed;
    logic [FRAMES_W-1:0] clear_frames_needed;
  } decide_cfg_t;

endpackage

@@ rtl/core/vbfd_front.sv @@
// Pixel counter: counts total and dark pixels and emits a summary at frame end.
`timescale 1ns / 1ps

module vbfd_front import vbfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pix_accept,
  input  logic [LUMA_W-1:0]  pix_luma,
  input  logic               pix_last,
  input  logic [THR_W-1:0]   pixel_threshold,
  output logic               stats_push,
  output frame_stats_t       stats_data
);

  logic [COUNT_W-1:0] dark_r, dark_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               dark_hit;

  assign dark_hit = {1'b0, pix_luma} < pixel_threshold;

  always_comb begin
    total_nxt = (total_r < MAX_FRAME_PIXELS) ? total_r + 1'b1 : MAX_FRAME_PIXELS;
    dark_nxt  = dark_r;
    if (dark_hit) begin
      dark_nxt = (dark_r < MAX_FRAME_PIXELS) ? dark_r + 1'b1 : MAX_FRAME_PIXELS;
    end
  end

  // The last pixel is counted with its frame, so the summary carries the
  // updated counts.
  assign stats_push       = pix_accept & pix_last;
  assign stats_data.dark  = dark_nxt;
  assign stats_data.total = total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r  <= '0;
      total_r <= '0;
    end else if (pix_accept) begin
      if (pix_last) begin
        dark_r  <= '0;
        total_r <= '0;
      end else begin
        dark_r  <= dark_nxt;
        total_r <= total_nxt;
      end
    end
  end

endmodule

@@ rtl/core/vbfd_queue.sv @@
// Small queue of frame summaries between the counter and the decision stage.
`timescale 1ns / 1ps

module vbfd_queue import vbfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  frame_stats_t push_data,
  input  logic         pop,
  output frame_stats_t pop_data,
  output logic         full,
  output logic         empty
);

  frame_stats_t       mem [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r;
  logic [QAW-1:0]     rd_ptr_r;
  logic [QCW-1:0]     count_r;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == QCW'(QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/core/vbfd_back.sv @@
// Decision stage: percentage test, hysteresis run counters and output register.
`timescale 1ns / 1ps

module vbfd_back import vbfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  decide_cfg_t        cfg,
  input  logic               q_empty,
  input  frame_stats_t       q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_frame_black,
  output logic               out_black_state
);

  logic              prod_valid_r;
  logic [PROD_W-1:0] lhs_r;
  logic [PROD_W-1:0] rhs_r;
  logic              prod_ready;
  logic              res_load;

  logic [RUN_W-1:0]  black_run_r, black_run_nxt;
  logic [RUN_W-1:0]  clear_run_r, clear_run_nxt;
  logic              black_flag_r, black_flag_nxt;
  logic [RUN_W-1:0]  black_inc;
  logic [RUN_W-1:0]  clear_inc;
  logic              frame_black;

  logic              out_valid_r;
  logic              out_frame_black_r;
  logic              out_black_state_r;

  assign res_load   = prod_valid_r & (~out_valid_r | out_ready);
  assign prod_ready = ~prod_valid_r | res_load;
  assign q_pop      = ~q_empty & prod_ready;

  // Products are registered before the compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (prod_ready) begin
      prod_valid_r <= ~q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      lhs_r <= PROD_W'(q_data.dark) * PROD_W'(PCT_SCALE);
      rhs_r <= PROD_W'(cfg.percent_black) * PROD_W'(q_data.total);
    end
  end

  assign frame_black = lhs_r >= rhs_r;
  assign black_inc   = (black_run_r < RUN_MAX) ? black_run_r + 1'b1 : RUN_MAX;
  assign clear_inc   = (clear_run_r < RUN_MAX) ? clear_run_r + 1'b1 : RUN_MAX;

  // Neither run is cleared by a frame of the other kind; only a run passing its
  // target clears both.
  always_comb begin
    black_run_nxt  = black_run_r;
    clear_run_nxt  = clear_run_r;
    black_flag_nxt = black_flag_r;
    if (frame_black) begin
      black_run_nxt = black_inc;
      if (black_inc > RUN_W'(cfg.black_frames_needed)) begin
        black_run_nxt  = '0;
        clear_run_nxt  = '0;
        black_flag_nxt = 1'b1;
      end
    end else begin
      clear_run_nxt = clear_inc;
      if (clear_inc > RUN_W'(cfg.clear_frames_needed)) begin
        black_run_nxt  = '0;
        clear_run_nxt  = '0;
        black_flag_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_run_r  <= '0;
      clear_run_r  <= '0;
      black_flag_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (res_load) begin
        black_run_r  <= black_run_nxt;
        clear_run_r  <= clear_run_nxt;
        black_flag_r <= black_flag_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_frame_black_r <= frame_black;
      out_black_state_r <= black_flag_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_black = out_frame_black_r;
  assign out_black_state = out_black_state_r;

endmodule

@@ rtl/core/video_black_frame_detector.sv @@
// Black frame detector: luma pixels in, one result per frame out.
// Throughput: one pixel per cycle while the queue is not full; frame results
// can also issue one per cycle while out_tready is high.
// A four-entry summary queue lets the pixel side run while the result waits.
// Reset (rst_n, synchronous, active low) restores default configuration,
// clears counts and runs, and sets the sticky black state to one.
`timescale 1ns / 1ps

module video_black_frame_detector import vbfd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [LUMA_W-1:0]   in_tdata,   // [7:0] luma
  input  logic                in_tlast,   // frame_end
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_DW-1:0]   out_tdata,  // [0] frame_black, [1] black_state, rest zero
  input  logic                cfg_wr_en,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata
);

  logic [THR_W-1:0]    pixel_threshold_r;
  logic [PCT_W-1:0]    percent_black_r;
  logic [FRAMES_W-1:0] black_frames_needed_r;
  logic [FRAMES_W-1:0] clear_frames_needed_r;

  logic         pix_accept;
  logic         stats_push;
  frame_stats_t stats_data;
  frame_stats_t q_data;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;
  decide_cfg_t  decide_cfg;
  logic         frame_black;
  logic         black_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_threshold_r     <= RST_PIXEL_THRESHOLD;
      percent_black_r       <= RST_PERCENT_BLACK;
      black_frames_needed_r <= RST_BLACK_FRAMES_NEEDED;
      clear_frames_needed_r <= RST_CLEAR_FRAMES_NEEDED;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_PIXEL_THRESHOLD:     pixel_threshold_r     <= cfg_wdata[THR_W-1:0];
        REG_PERCENT_BLACK:       percent_black_r       <= cfg_wdata[PCT_W-1:0];
        REG_BLACK_FRAMES_NEEDED: black_frames_needed_r <= cfg_wdata[FRAMES_W-1:0];
        REG_CLEAR_FRAMES_NEEDED: clear_frames_needed_r <= cfg_wdata[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  assign decide_cfg.percent_black       = percent_black_r;
  assign decide_cfg.black_frames_needed = black_frames_needed_r;
  assign decide_cfg.clear_frames_needed = clear_frames_needed_r;

  assign in_tready  = ~q_full;
  assign pix_accept = in_tvalid & in_tready;

  vbfd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .pix_accept      (pix_accept),
    .pix_luma        (in_tdata),
    .pix_last        (in_tlast),
    .pixel_threshold (pixel_threshold_r),
    .stats_push      (stats_push),
    .stats_data      (stats_data)
  );

  vbfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (stats_push),
    .push_data (stats_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  vbfd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (decide_cfg),
    .q_empty         (q_empty),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_frame_black (frame_black),
    .out_black_state (black_state)
  );

  assign out_tdata = {{(OUT_DW-2){1'b0}}, black_state, frame_black};

endmodule

@@ tb/sv/vbfd_verdict_checker.sv @@
// Frame verdict checker for the black frame detector: predicts and compares each frame result.
`timescale 1ns / 1ps

module vbfd_verdict_checker import vbfd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [LUMA_W-1:0]   in_tdata,   // [7:0] luma
  input  logic                in_tlast,   // frame_end
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OUT_DW-1:0]   out_tdata,  // [0] frame_black, [1] black_state, rest zero
  input  logic                cfg_wr_en,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  output int                  fail_count,
  output int                  verdicts_pending
);

  typedef struct packed {
    logic frame_black;
    logic black_state;
  } verdict_t;

  // Shadow copy of the configuration.
  logic [THR_W-1:0]    dark_limit;
  logic [PCT_W-1:0]    pct_needed;
  logic [FRAMES_W-1:0] black_needed;
  logic [FRAMES_W-1:0] clear_needed;

  // Shadow copy of the frame counts and the hysteresis state.
  logic [COUNT_W-1:0]  dark_pixels;
  logic [COUNT_W-1:0]  frame_pixels;
  logic [RUN_W-1:0]    black_streak;
  logic [RUN_W-1:0]    clear_streak;
  logic                sticky_black;

  verdict_t expected_verdicts[$];
  int       mismatches = 0;
  int       verdicts_checked = 0;

  task automatic count_pixel(input logic [LUMA_W-1:0] luma, input logic last);
    logic [63:0] dark_scaled;
    logic [63:0] needed_scaled;
    verdict_t    verdict;
    if (frame_pixels < MAX_FRAME_PIXELS) frame_pixels = frame_pixels + 1'b1;
    if ({1'b0, luma} < dark_limit && dark_pixels < MAX_FRAME_PIXELS)
      dark_pixels = dark_pixels + 1'b1;
    if (last) begin
      dark_scaled   = 64'(dark_pixels) * 64'd100;
      needed_scaled = 64'(pct_needed) * 64'(frame_pixels);
      verdict.frame_black = (dark_scaled >= needed_scaled);
      // Each run only clears when either one trips, never on the other kind of frame.
      if (verdict.frame_black) begin
        if (black_streak != RUN_MAX) black_streak = black_streak + 1'b1;
        if (black_streak > RUN_W'(black_needed)) begin
          black_streak = '0;
          clear_streak = '0;
          sticky_black = 1'b1;
        end
      end else begin
        if (clear_streak != RUN_MAX) clear_streak = clear_streak + 1'b1;
        if (clear_streak > RUN_W'(clear_needed)) begin
          black_streak = '0;
          clear_streak = '0;
          sticky_black = 1'b0;
        end
      end
      verdict.black_state = sticky_black;
      expected_verdicts.push_back(verdict);
      dark_pixels  = '0;
      frame_pixels = '0;
    end
  endtask

  always @(posedge clk) begin : watch
    verdict_t got;
    verdict_t want;
    if (!rst_n) begin
      dark_limit   = RST_PIXEL_THRESHOLD;
      pct_needed   = RST_PERCENT_BLACK;
      black_needed = RST_BLACK_FRAMES_NEEDED;
      clear_needed = RST_CLEAR_FRAMES_NEEDED;
      dark_pixels  = '0;
      frame_pixels = '0;
      black_streak = '0;
      clear_streak = '0;
      sticky_black = 1'b1;
      expected_verdicts.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_PIXEL_THRESHOLD:     dark_limit   = cfg_wdata[THR_W-1:0];
          REG_PERCENT_BLACK:       pct_needed   = cfg_wdata[PCT_W-1:0];
          REG_BLACK_FRAMES_NEEDED: black_needed = cfg_wdata[FRAMES_W-1:0];
          REG_CLEAR_FRAMES_NEEDED: clear_needed = cfg_wdata[FRAMES_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) count_pixel(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.frame_black = out_tdata[0];
        got.black_state = out_tdata[1];
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected frame result at %0t: frame_black=%0b black_state=%0b",
                     $realtime, got.frame_black, got.black_state);
        end else begin
          want = expected_verdicts.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Frame result %0d at %0t: expected %0b/%0b, got %0b/%0b",
                       verdicts_checked, $realtime, want.frame_black, want.black_state,
                       got.frame_black, got.black_state);
          end
        end
        verdicts_checked++;
      end
    end
    verdicts_pending <= expected_verdicts.size();
    fail_count       <= mismatches;
  end

endmodule

@@ tb/sv/tb_video_black_frame_detector.sv @@
// Testbench top for the black frame detector: stimulus, flow control and the final verdict.
`timescale 1ns / 1ps

module tb_video_black_frame_detector import vbfd_pkg::*; ();

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [LUMA_W-1:0] in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tready = 1'b0;
  logic              cfg_wr_en  = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [CFG_DW-1:0] cfg_wdata  = '0;
  logic              in_tready;
  logic              out_tvalid;
  logic [OUT_DW-1:0] out_tdata;

  int fail_count;
  int verdicts_pending;

  logic [THR_W-1:0] active_thr = RST_PIXEL_THRESHOLD;
  bit feed_steady  = 1'b0;
  bit drain_steady = 1'b0;
  int pixels_sent  = 0;
  int frames_sent  = 0;
  int setups_done  = 0;

  always #5 clk = ~clk;

  video_black_frame_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  vbfd_verdict_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tlast         (in_tlast),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending)
  );

  // One pixel transaction, preceded by a random gap unless the sender runs steady.
  task automatic feed_pixel(input logic [LUMA_W-1:0] luma, input logic last);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= luma;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
    if (last) frames_sent++;
  endtask

  // Hold the sender until every frame result is back, then let the pipeline go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_setup(input logic [CFG_DW-1:0] thr, input logic [CFG_DW-1:0] pct,
                            input logic [CFG_DW-1:0] black_need,
                            input logic [CFG_DW-1:0] clear_need);
    settle();
    put_reg(REG_PIXEL_THRESHOLD, thr);
    put_reg(REG_PERCENT_BLACK, pct);
    put_reg(REG_BLACK_FRAMES_NEEDED, black_need);
    put_reg(REG_CLEAR_FRAMES_NEEDED, clear_need);
    cfg_wr_en  <= 1'b0;
    active_thr = thr[THR_W-1:0];
    setups_done++;
  endtask

  function automatic logic [LUMA_W-1:0] pick_luma(input bit dark);
    if (dark && active_thr > 0)
      return LUMA_W'($urandom_range(0, (active_thr > 256) ? 255 : active_thr - 1));
    if (!dark && active_thr <= 255)
      return LUMA_W'($urandom_range(active_thr, 255));
    return LUMA_W'($urandom_range(0, 255));
  endfunction

  task automatic feed_frame(input int len, input int dark_pct);
    for (int i = 0; i < len; i++)
      feed_pixel(pick_luma($urandom_range(0, 99) < dark_pct), i == len - 1);
  endtask

  function automatic logic [CFG_DW-1:0] pick_thr();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_DW'(256);
      2:       return CFG_DW'($urandom_range(0, 16'hFFFF));
      default: return CFG_DW'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] pick_pct();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_DW'(100);
      2:       return CFG_DW'($urandom_range(101, 16'hFFFF));
      default: return CFG_DW'($urandom_range(1, 100));
    endcase
  endfunction

  // Run targets are mostly small, to keep the hysteresis switching within a short phase.
  function automatic logic [CFG_DW-1:0] pick_need();
    case ($urandom_range(0, 7))
      0:       return 16'hFFFF;
      1:       return CFG_DW'($urandom_range(0, 16'hFFFF));
      default: return CFG_DW'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin : drain
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = drain_steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    int frame_len;
    int dark_pct;
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: a black frame, a bright one that flips the state, threshold edge.
    feed_pixel(8'd0, 1'b1);
    feed_pixel(8'd255, 1'b1);
    feed_pixel(8'd31, 1'b0);
    feed_pixel(8'd32, 1'b1);

    // Threshold above the luma range makes every pixel dark.
    load_setup(16'd256, 16'd100, 16'd0, 16'd0);
    feed_pixel(8'd255, 1'b1);
    feed_pixel(8'd128, 1'b0);
    feed_pixel(8'd255, 1'b1);

    // Half-dark frames sit exactly on the percentage; runs need two frames to switch.
    load_setup(16'd1, 16'd50, 16'd1, 16'd1);
    feed_pixel(8'd0, 1'b0);
    feed_pixel(8'd1, 1'b1);
    feed_pixel(8'd1, 1'b0);
    feed_pixel(8'd1, 1'b1);
    feed_pixel(8'd1, 1'b0);
    feed_pixel(8'd1, 1'b1);
    feed_pixel(8'd0, 1'b0);
    feed_pixel(8'd0, 1'b1);

    // Zero percent with no dark pixels still counts as black.
    load_setup(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    feed_pixel(8'd200, 1'b1);
    feed_pixel(8'd7, 1'b1);

    // All-ones writes: the percentage exceeds one hundred, so no frame is black.
    load_setup(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    feed_pixel(8'd0, 1'b0);
    feed_pixel(8'd0, 1'b1);

    while (pixels_sent < 420) begin
      load_setup(pick_thr(), pick_pct(), pick_need(), pick_need());
      feed_steady  = ($urandom_range(0, 3) == 0);
      drain_steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) begin
        frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
        case ($urandom_range(0, 3))
          0:       dark_pct = 100;
          1:       dark_pct = 0;
          2:       dark_pct = $urandom_range(85, 99);
          default: dark_pct = $urandom_range(0, 100);
        endcase
        feed_frame(frame_len, dark_pct);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (verdicts_pending != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d pixels in %0d frames across %0d register setups.",
             pixels_sent, frames_sent, setups_done + 1);
    $display("Setups included all-dark, none-dark, zero and over-range percentages.");
    if (verdicts_pending != 0)
      $display("%0d frame results never arrived.", verdicts_pending);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Simulation timed out.");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
